// ===== rtl/core/differential_drive_odometry_unit_defines.svh =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit_defines.svh
// Assertion shorthands shared by the odometry unit's checker
// ----------------------------------------------------------------------------
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_UNIT_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during rst
`define ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, quiet during rst
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ddo_pkg.sv =====
// ----------------------------------------------------------------------------
// ddo_pkg
// Types and constants of the differential drive odometry unit
// ----------------------------------------------------------------------------
`default_nettype none

package ddo_pkg;

  // cordic table length and start gain (0.6072529350 in Q1.30)
  localparam int ATAN_ENTRIES = 24;
  localparam logic signed [31:0] KINV_Q30 = 32'sd652032874;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
    32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
    32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
    32'd166886,    32'd83443,     32'd41722,     32'd20861,
    32'd10430,     32'd5215,      32'd2608,      32'd1304,
    32'd652,       32'd326,       32'd163,       32'd81
  };

  // travel in Q.16 metres
  localparam int TRAVEL_W = 48;

  // register indexes on the configuration port
  localparam logic REG_METRES_PER_COUNT = 1'b0;
  localparam logic REG_TURN_GAIN        = 1'b1;

  // one encoder and compass sample
  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic signed [15:0] compass_heading;
  } in_item_t;

  // one pose result
  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] odo_angle;
  } out_item_t;

  // rotation vector handed from cell to cell
  typedef struct packed {
    logic               flip;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cordic_vec_t;

endpackage

`default_nettype wire

// ===== rtl/core/ddo_cordic_cell.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic_cell
// One rotation-mode cordic step with a fixed shift, registered output
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic_cell #(
  parameter int STEP = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 valid_in,
  input  ddo_pkg::cordic_vec_t vec_in,
  output logic                 valid_out,
  output ddo_pkg::cordic_vec_t vec_out
);
  import ddo_pkg::*;

  localparam logic signed [31:0] ATAN = $signed(ATAN_TURNS[STEP]);

  logic signed [31:0] xs;
  logic signed [31:0] ys;
  cordic_vec_t        vec_next;

  // rotate toward zero residual angle
  always_comb begin
    xs = $signed(vec_in.x) >>> STEP;
    ys = $signed(vec_in.y) >>> STEP;
    vec_next.flip = vec_in.flip;
    if (!vec_in.z[31]) begin
      vec_next.x = vec_in.x - ys;
      vec_next.y = vec_in.y + xs;
      vec_next.z = vec_in.z - ATAN;
    end else begin
      vec_next.x = vec_in.x + ys;
      vec_next.y = vec_in.y - xs;
      vec_next.z = vec_in.z + ATAN;
    end
  end

  // hand to the neighbor
  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else begin
      valid_out <= valid_in;
    end
    vec_out <= vec_next;
  end

endmodule

`default_nettype wire

// ===== rtl/core/ddo_cordic_chain.sv =====
// ----------------------------------------------------------------------------
// ddo_cordic_chain
// Quadrant fold, a row of cordic cells and a registered cos/sin output
// ----------------------------------------------------------------------------
`default_nettype none

module ddo_cordic_chain #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic               done,
  output logic signed [31:0] cos_q30,
  output logic signed [31:0] sin_q30
);
  import ddo_pkg::*;

  localparam int NCELLS = (CORDIC_STEPS > ATAN_ENTRIES) ? ATAN_ENTRIES : CORDIC_STEPS;

  logic              flip;
  cordic_vec_t       first_vec;
  logic [NCELLS-1:0] cell_valid;
  cordic_vec_t       cell_vec [NCELLS];

  // fold the left half plane over by a half turn
  always_comb begin
    flip            = angle[31] ^ angle[30];
    first_vec.flip  = flip;
    first_vec.x     = KINV_Q30;
    first_vec.y     = '0;
    first_vec.z     = {angle[31] ^ flip, angle[30:0]};
  end

  // row of cells, one shift each
  for (genvar g = 0; g < NCELLS; g++) begin : g_cell
    if (g == 0) begin : g_head
      ddo_cordic_cell #(.STEP(g)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (start),
        .vec_in    (first_vec),
        .valid_out (cell_valid[g]),
        .vec_out   (cell_vec[g])
      );
    end else begin : g_body
      ddo_cordic_cell #(.STEP(g)) u_cell (
        .clk       (clk),
        .rst       (rst),
        .valid_in  (cell_valid[g-1]),
        .vec_in    (cell_vec[g-1]),
        .valid_out (cell_valid[g]),
        .vec_out   (cell_vec[g])
      );
    end
  end

  // undo the fold and register the result
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cell_valid[NCELLS-1];
    end
    cos_q30 <= cell_vec[NCELLS-1].flip ? -cell_vec[NCELLS-1].x : cell_vec[NCELLS-1].x;
    sin_q30 <= cell_vec[NCELLS-1].flip ? -cell_vec[NCELLS-1].y : cell_vec[NCELLS-1].y;
  end

endmodule

`default_nettype wire

// ===== rtl/core/differential_drive_odometry_unit.sv =====
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// Wheel odometry: encoder deltas to travel and turn, cordic projection, pose
// sums. Samples enter on in_valid/in_ready, one pose per sample leaves on
// out_valid/out_ready; both channels are valid/ready handshakes.
// metres_per_count (address 0) and turn_gain (address 4) sit on the APB port.
// One transaction at a time: a sample passes the states MUL1, MUL2, TURN,
// START, ROT (the row of cordic cells), SUM and OUT before its result is in
// the output register, and the next sample is taken only back in IDLE.
// Besides the row of cordic cells, the path holds three multiply stages.
// The output register holds a stalled result while the next sample is
// worked on; the pose sums only advance once the output register is free.
// Reset clears the state, out_valid, the configuration, the encoder history and the pose sums.
// ----------------------------------------------------------------------------
`default_nettype none

module differential_drive_odometry_unit #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ddo_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ddo_pkg::out_item_t out_data,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import ddo_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_MUL1  = 8'b0000_0010,
    S_MUL2  = 8'b0000_0100,
    S_TURN  = 8'b0000_1000,
    S_START = 8'b0001_0000,
    S_ROT   = 8'b0010_0000,
    S_SUM   = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state;
  state_t state_next;

  // configuration and history
  logic [31:0] metres_per_count;
  logic [31:0] turn_gain;
  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic [31:0] acc_x;
  logic [31:0] acc_y;
  logic [31:0] acc_angle;
  logic [31:0] acc_x_next;
  logic [31:0] acc_y_next;
  logic [31:0] acc_angle_next;

  // working registers
  logic signed [32:0]         dsum;
  logic signed [32:0]         ddiff;
  logic [15:0]                head;
  logic signed [TRAVEL_W-1:0] travel;
  logic [63:0]                dprod;
  logic [31:0]                turn_hi;
  logic [31:0]                turn_lo;
  logic [31:0]                turn;
  logic [31:0]                ang;
  logic signed [63:0]         px_hi;
  logic signed [63:0]         py_hi;
  logic signed [48:0]         px_lo;
  logic signed [48:0]         py_lo;
  logic [31:0]                dx;
  logic [31:0]                dy;

  // combinational terms
  logic               in_fire;
  logic               cfg_we;
  logic               out_load;
  logic [31:0]        dl;
  logic [31:0]        dr;
  logic signed [32:0] sum_c;
  logic signed [32:0] diff_c;
  logic signed [32:0] mpc_s;
  logic signed [65:0] travel_prod;
  logic signed [65:0] diff_prod;
  logic [31:0]        turn_hi_c;
  logic [63:0]        turn_lo_c;
  logic [31:0]        turn_c;
  logic [31:0]        half_c;
  logic [31:0]        ang_c;
  logic signed [31:0] trav_hi;
  logic signed [16:0] trav_lo;
  logic signed [63:0] px_hi_c;
  logic signed [63:0] py_hi_c;
  logic signed [48:0] px_lo_c;
  logic signed [48:0] py_lo_c;
  logic [63:0]        fx;
  logic [63:0]        fy;
  logic               cs_done;
  logic signed [31:0] cos_q30;
  logic signed [31:0] sin_q30;

  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign cfg_we   = psel && penable && pwrite;
  assign out_load = (state == S_OUT) && (!out_valid || out_ready);
  assign pready   = 1'b1;

  // register read mux
  always_comb begin
    case (paddr[2])
      REG_METRES_PER_COUNT: prdata = metres_per_count;
      REG_TURN_GAIN:        prdata = turn_gain;
      default:              prdata = '0;
    endcase
  end

  // wrapped encoder deltas, their sum and difference
  assign dl     = in_data.left_count - prev_left;
  assign dr     = in_data.right_count - prev_right;
  assign sum_c  = $signed({dl[31], dl}) + $signed({dr[31], dr});
  assign diff_c = $signed({dr[31], dr}) - $signed({dl[31], dl});

  // scale to metres
  assign mpc_s       = $signed({1'b0, metres_per_count});
  assign travel_prod = 66'(dsum) * 66'(mpc_s);
  assign diff_prod   = 66'(ddiff) * 66'(mpc_s);

  // turn = upper word of the 64-bit wrapped product times the gain
  assign turn_hi_c = dprod[63:32] * turn_gain;
  assign turn_lo_c = 64'(dprod[31:0]) * 64'(turn_gain);

  // cordic angle: heading plus half the turn
  assign turn_c = turn_hi + turn_lo;
  assign half_c = {turn_c[31], turn_c[31:1]};
  assign ang_c  = {head, 16'h0000} + half_c;

  ddo_cordic_chain #(.CORDIC_STEPS(CORDIC_STEPS)) u_chain (
    .clk     (clk),
    .rst     (rst),
    .start   (state == S_START),
    .angle   (ang),
    .done    (cs_done),
    .cos_q30 (cos_q30),
    .sin_q30 (sin_q30)
  );

  // projection split into upper and lower travel partial products
  assign trav_hi = travel[TRAVEL_W-1:16];
  assign trav_lo = $signed({1'b0, travel[15:0]});
  assign px_hi_c = 64'(trav_hi) * 64'(cos_q30);
  assign py_hi_c = 64'(trav_hi) * 64'(sin_q30);
  assign px_lo_c = 49'(trav_lo) * 49'(cos_q30);
  assign py_lo_c = 49'(trav_lo) * 49'(sin_q30);

  assign fx = {px_hi[47:0], 16'h0000} + {{15{px_lo[48]}}, px_lo};
  assign fy = {py_hi[47:0], 16'h0000} + {{15{py_lo[48]}}, py_lo};

  // pose sums
  assign acc_x_next     = acc_x + dx;
  assign acc_y_next     = acc_y + dy;
  assign acc_angle_next = acc_angle + turn;

  // sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (in_valid) state_next = S_MUL1;
      S_MUL1:  state_next = S_MUL2;
      S_MUL2:  state_next = S_TURN;
      S_TURN:  state_next = S_START;
      S_START: state_next = S_ROT;
      S_ROT:   if (cs_done) state_next = S_SUM;
      S_SUM:   state_next = S_OUT;
      S_OUT:   if (!out_valid || out_ready) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control state, configuration, history and sums
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      out_valid        <= 1'b0;
      metres_per_count <= '0;
      turn_gain        <= '0;
      prev_left        <= '0;
      prev_right       <= '0;
      acc_x            <= '0;
      acc_y            <= '0;
      acc_angle        <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (paddr[2])
          REG_METRES_PER_COUNT: metres_per_count <= pwdata;
          REG_TURN_GAIN:        turn_gain <= pwdata;
          default:              ;
        endcase
      end
      if (in_fire) begin
        prev_left  <= in_data.left_count;
        prev_right <= in_data.right_count;
      end
      if (out_load) begin
        acc_x     <= acc_x_next;
        acc_y     <= acc_y_next;
        acc_angle <= acc_angle_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      dsum  <= sum_c;
      ddiff <= diff_c;
      head  <= in_data.compass_heading;
    end
    if (state == S_MUL1) begin
      travel <= travel_prod[TRAVEL_W+16:17];
      dprod  <= diff_prod[63:0];
    end
    if (state == S_MUL2) begin
      turn_hi <= turn_hi_c;
      turn_lo <= turn_lo_c[63:32];
    end
    if (state == S_TURN) begin
      turn <= turn_c;
      ang  <= ang_c;
    end
    if ((state == S_ROT) && cs_done) begin
      px_hi <= px_hi_c;
      py_hi <= py_hi_c;
      px_lo <= px_lo_c;
      py_lo <= py_lo_c;
    end
    if (state == S_SUM) begin
      dx <= fx[61:30];
      dy <= fy[61:30];
    end
    if (out_load) begin
      out_data.pos_x     <= acc_x_next;
      out_data.pos_y     <= acc_y_next;
      out_data.odo_angle <= acc_angle_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/ddo_checker.sv =====
// ----------------------------------------------------------------------------
// ddo_checker
// Port-level checks of the odometry unit, bound to its top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "differential_drive_odometry_unit_defines.svh"

module ddo_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input ddo_pkg::out_item_t out_data
);

  // a stalled result stays put
  `ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "result changed while stalled")

  // one sample in flight at a time
  `ASSERT_NEXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second transaction taken while busy")

  // a new pose never shows the cycle after a sample is taken
  `ASSERT_NEXT(a_no_early_result, in_valid && in_ready, !$rose(out_valid), "result appeared too early")

  // coming out of reset idle and empty
  `ASSERT_NOW(a_reset_idle, $past(rst), in_ready && !out_valid, "not idle after reset")

endmodule

bind differential_drive_odometry_unit ddo_checker u_ddo_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
